### hw/rtl/utf8v_pkg.sv
package utf8v_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned AccW   = 21;
  localparam int unsigned LeftW  = 2;
  localparam int unsigned ClassW = 2;

  localparam logic [LeftW-1:0]  LeftNone = 2'd0;
  localparam logic [LeftW-1:0]  LeftOne  = 2'd1;

  localparam logic [ClassW-1:0] ClsAscii = 2'd0;
  localparam logic [ClassW-1:0] ClsTwo   = 2'd1;
  localparam logic [ClassW-1:0] ClsThree = 2'd2;
  localparam logic [ClassW-1:0] ClsFour  = 2'd3;

  localparam logic [ByteW-1:0] ByteNul      = 8'h00;
  localparam logic [ByteW-1:0] LeadTwoMin   = 8'hC0;
  localparam logic [ByteW-1:0] LeadThreeMin = 8'hE0;
  localparam logic [ByteW-1:0] LeadFourMin  = 8'hF0;
  localparam logic [ByteW-1:0] LeadMax      = 8'hF4;
  localparam logic [1:0]       ContTag      = 2'b10;

  typedef struct packed {
    logic valid;
    logic ok;
  } verdict_t;

  function automatic logic [AccW-1:0] lead_bits(input logic [ClassW-1:0] cls,
                                                input logic [ByteW-1:0] b);
    logic [ByteW-1:0] m;
    case (cls)
      ClsAscii: m = 8'h7F;
      ClsTwo:   m = 8'h1F;
      ClsThree: m = 8'h0F;
      ClsFour:  m = 8'h07;
      default:  m = 8'h00;
    endcase
    return {{(AccW-ByteW){1'b0}}, b & m};
  endfunction

  function automatic logic in_range(input logic [ClassW-1:0] cls,
                                    input logic [AccW-1:0] v);
    logic [AccW-1:0] lo;
    logic [AccW-1:0] hi;
    case (cls)
      ClsAscii: begin lo = 21'h000000; hi = 21'h00007F; end
      ClsTwo:   begin lo = 21'h000080; hi = 21'h0007FF; end
      ClsThree: begin lo = 21'h000800; hi = 21'h00FFFF; end
      ClsFour:  begin lo = 21'h010000; hi = 21'h10FFFF; end
      default:  begin lo = 21'h000000; hi = 21'h000000; end
    endcase
    return (v >= lo) && (v <= hi);
  endfunction

endpackage

### hw/rtl/utf8v_core.sv
module utf8v_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  logic [utf8v_pkg::ByteW-1:0] text_byte,
  output utf8v_pkg::verdict_t         verdict
);
  import utf8v_pkg::*;

  logic [LeftW-1:0]  bytes_left, bytes_left_next;
  logic [ClassW-1:0] seq_class, seq_class_next;
  logic [AccW-1:0]   code_accum, code_accum_next;
  logic              error_seen, error_seen_next;
  logic [AccW-1:0]   shifted;
  logic [ClassW-1:0] lead_cls;

  assign shifted = {code_accum[AccW-7:0], text_byte[5:0]};

  always_comb begin
    if (text_byte < LeadThreeMin) begin
      lead_cls = ClsTwo;
    end else if (text_byte < LeadFourMin) begin
      lead_cls = ClsThree;
    end else begin
      lead_cls = ClsFour;
    end
  end

  always_comb begin
    bytes_left_next = bytes_left;
    seq_class_next  = seq_class;
    code_accum_next = code_accum;
    error_seen_next = error_seen;
    verdict.valid   = 1'b0;
    verdict.ok      = !error_seen && (bytes_left == LeftNone);
    if (take) begin
      if (text_byte == ByteNul) begin
        verdict.valid   = 1'b1;
        bytes_left_next = LeftNone;
        seq_class_next  = ClsAscii;
        code_accum_next = '0;
        error_seen_next = 1'b0;
      end else if (!error_seen) begin
        if (bytes_left == LeftNone) begin
          if (text_byte[7]) begin
            if (text_byte < LeadTwoMin || text_byte > LeadMax) begin
              error_seen_next = 1'b1;
            end else begin
              seq_class_next  = lead_cls;
              bytes_left_next = lead_cls;
              code_accum_next = lead_bits(lead_cls, text_byte);
            end
          end
        end else if (text_byte[7:6] != ContTag) begin
          error_seen_next = 1'b1;
        end else begin
          code_accum_next = shifted;
          bytes_left_next = bytes_left - LeftOne;
          if (bytes_left == LeftOne && !in_range(seq_class, shifted)) begin
            error_seen_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= LeftNone;
      seq_class  <= ClsAscii;
      code_accum <= '0;
      error_seen <= 1'b0;
    end else begin
      bytes_left <= bytes_left_next;
      seq_class  <= seq_class_next;
      code_accum <= code_accum_next;
      error_seen <= error_seen_next;
    end
  end

endmodule

### hw/rtl/utf8_string_validator.sv
// Checks NUL-terminated byte strings for well-formed UTF-8, one byte per
// transfer on the slave side. Every byte is taken in the cycle it arrives
// while s_tready is high (one byte per clock sustained unless two verdicts
// wait); only the terminating zero byte yields a master-side transfer, whose
// bit 0 is 1 for a valid string. Overlong forms and values above 0x10FFFF
// are rejected, surrogates are accepted, and a zero byte in the middle of a
// sequence gives a 0 verdict. A two-entry result buffer lets input continue
// while a verdict waits; s_tready falls only when two verdicts are waiting.
module utf8_string_validator (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] string_ok, [7:1] zero
);
  import utf8v_pkg::*;

  verdict_t verdict;
  logic     take;
  logic     pop;
  logic     main_ok;
  logic     skid_valid;
  logic     skid_ok;

  assign s_tready = !skid_valid;
  assign take     = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = {7'b0, main_ok};

  utf8v_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .text_byte (s_tdata),
    .verdict   (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_ok    <= skid_ok;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= verdict.valid;
        main_ok  <= verdict.ok;
      end
    end else if (verdict.valid) begin
      if (!m_tvalid) begin
        m_tvalid <= 1'b1;
        main_ok  <= verdict.ok;
      end else begin
        skid_valid <= 1'b1;
        skid_ok    <= verdict.ok;
      end
    end
  end

endmodule
